### sv/dad_pkg.sv
`default_nettype none
package dad_pkg;

  localparam int unsigned DutyW = 7;
  localparam int unsigned StepW = 6;
  localparam int unsigned LimW  = 8;

  localparam logic [DutyW-1:0] DutyCeil = 7'd100;
  localparam logic [StepW-1:0] StepMin  = 6'd10;
  localparam logic [StepW-1:0] StepMax  = 6'd50;

  typedef enum logic [1:0] {
    DRIVE_STOP  = 2'd0,
    DRIVE_RAISE = 2'd1,
    DRIVE_LOWER = 2'd2
  } drive_e;

  typedef enum logic [2:0] {
    CFG_DEADBAND   = 3'd0,
    CFG_NEAR_LIMIT = 3'd1,
    CFG_MID_LIMIT  = 3'd2,
    CFG_LOW_DUTY   = 3'd3,
    CFG_MID_DUTY   = 3'd4,
    CFG_MAX_DUTY   = 3'd5,
    CFG_RAMP_STEP  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [LimW-1:0]  deadband;
    logic [LimW-1:0]  near_limit;
    logic [LimW-1:0]  mid_limit;
    logic [DutyW-1:0] low_duty;
    logic [DutyW-1:0] mid_duty;
    logic [DutyW-1:0] max_duty;
    logic [StepW-1:0] ramp_step;
  } cfg_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    drive_e           drive;
    logic [DutyW-1:0] goal;
    logic             ramp;
  } cmd_t;

endpackage
`default_nettype wire

### sv/dad_front.sv
`default_nettype none
module dad_front
  import dad_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cfg_t                        cfg_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [POS_WIDTH-1:0] measured_i,
  input  wire logic signed [POS_WIDTH-1:0] target_i,
  output logic                             push_o,
  output cmd_t                             cmd_o,
  input  wire logic                        full_i
);

  logic                        in_valid_q, in_valid_d;
  logic signed [POS_WIDTH-1:0] meas_q, targ_q;
  drive_e                      dir_q, dir_d;

  logic signed [POS_WIDTH:0]   diff;
  logic        [POS_WIDTH:0]   err;
  logic        [DutyW-1:0]     sel_duty;
  logic        [DutyW-1:0]     goal;
  drive_e                      new_dir;
  logic                        in_band;
  logic                        accept;

  assign in_ready_o = !in_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = in_valid_q && !full_i;

  always_comb begin
    diff    = {meas_q[POS_WIDTH-1], meas_q} - {targ_q[POS_WIDTH-1], targ_q};
    err     = diff[POS_WIDTH] ? (~diff + 1'b1) : diff;
    in_band = err <= (POS_WIDTH+1)'(cfg_i.deadband);
    new_dir = diff[POS_WIDTH] ? DRIVE_RAISE : DRIVE_LOWER;
    priority if (err < (POS_WIDTH+1)'(cfg_i.near_limit)) begin
      sel_duty = cfg_i.low_duty;
    end else if (err < (POS_WIDTH+1)'(cfg_i.mid_limit)) begin
      sel_duty = cfg_i.mid_duty;
    end else begin
      sel_duty = cfg_i.max_duty;
    end
    goal = (sel_duty > DutyCeil) ? DutyCeil : sel_duty;

    if (in_band) begin
      cmd_o.drive = DRIVE_STOP;
      cmd_o.goal  = '0;
      cmd_o.ramp  = 1'b0;
    end else begin
      cmd_o.drive = new_dir;
      cmd_o.goal  = goal;
      cmd_o.ramp  = new_dir != dir_q;
    end

    dir_d = dir_q;
    if (push_o) begin
      dir_d = cmd_o.drive;
    end

    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (push_o) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      dir_q      <= DRIVE_STOP;
    end else begin
      in_valid_q <= in_valid_d;
      dir_q      <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= measured_i;
      targ_q <= target_i;
    end
  end

endmodule
`default_nettype wire

### sv/dad_fifo.sv
`default_nettype none
module dad_fifo
  import dad_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      pop_data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = count_q == FullCnt;
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### sv/dad_back.sv
`default_nettype none
module dad_back
  import dad_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             empty_i,
  input  wire cmd_t             cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output drive_e                drive_o,
  output logic [DutyW-1:0]      duty_o,
  output logic                  last_o
);

  logic             busy_q, busy_d;
  cmd_t             cmd_q;
  logic [DutyW-1:0] level_q;
  logic             out_valid_q, out_valid_d;
  drive_e           drive_q;
  logic [DutyW-1:0] duty_q;
  logic             last_q;

  logic [StepW-1:0] step;
  logic [DutyW:0]   sum;
  logic             fin;
  logic [DutyW-1:0] cur_duty;
  logic             load;

  always_comb begin
    priority if (cfg_i.ramp_step < StepMin) begin
      step = StepMin;
    end else if (cfg_i.ramp_step > StepMax) begin
      step = StepMax;
    end else begin
      step = cfg_i.ramp_step;
    end
    sum      = {1'b0, level_q} + (DutyW+1)'(step);
    fin      = cmd_q.ramp ? (sum > {1'b0, cmd_q.goal}) : 1'b1;
    cur_duty = cmd_q.ramp ? level_q : cmd_q.goal;
    load     = busy_q && (!out_valid_q || out_ready_i);
    pop_o    = !busy_q && !empty_i;

    busy_d = busy_q;
    if (pop_o) begin
      busy_d = 1'b1;
    end else if (load && fin) begin
      busy_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q   <= cmd_i;
      level_q <= '0;
    end else if (load && !fin) begin
      level_q <= sum[DutyW-1:0];
    end
    if (load) begin
      drive_q <= cmd_q.drive;
      duty_q  <= cur_duty;
      last_q  <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign duty_o      = duty_q;
  assign last_o      = last_q;

  // a stopped drive always carries zero duty and closes its transaction run
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (drive_q == DRIVE_STOP) |-> (duty_q == '0) && last_q)
    else $error("stop result with non-zero duty or without last");

  a_duty_ceil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> duty_q <= DutyCeil)
    else $error("duty above ceiling");

  a_ramp_climb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && cmd_q.ramp && !fin |=> level_q == $past(sum[DutyW-1:0]))
    else $error("ramp level did not advance by one step");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pop_o)
    else $error("queue popped while a command is in progress");

endmodule
`default_nettype wire

### sv/deadband_actuator_drive.sv
`default_nettype none
// Deadband actuator drive. Each input transaction carries a measured and a
// target position; the front stage registers it, forms the absolute error and
// classifies it (stop inside the deadband, else raise or lower with a low, mid
// or max duty), then pushes the command into a short queue. The back stage
// emits one result per cycle within a command while the output is not stalled:
// a single result when the direction is unchanged or the drive stops, or a
// ramp 0, step, 2*step ... (up to 11 results) after a change of direction.
// Each item takes a queue pop, then one result load per result; the back stage
// sets the sustained rate. The first result follows the front input register,
// the queue, the back command register and the output register. Configuration
// writes are always accepted and must only be made while the block is idle.
module deadband_actuator_drive
  import dad_pkg::*;
#(
  parameter int unsigned POS_WIDTH  = 12,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      s_axis_tvalid_i,
  output logic                                           s_axis_tready_o,
  // measured, target
  input  wire logic [((2 * POS_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                                           m_axis_tvalid_o,
  input  wire logic                                      m_axis_tready_i,
  // drive, duty_pct
  output logic [((2 + DutyW + 7) / 8) * 8 - 1:0]         m_axis_tdata_o,
  output logic                                           m_axis_tlast_o,
  input  wire logic                                      cfg_valid_i,
  output logic                                           cfg_ready_o,
  input  wire logic [2:0]                                cfg_index_i,
  input  wire logic [LimW-1:0]                           cfg_data_i
);

  localparam int unsigned OutBits  = 2 + DutyW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  cfg_t   cfg_q;
  logic   push, full, pop, empty;
  cmd_t   push_cmd, pop_cmd;
  drive_e drive;
  logic [DutyW-1:0] duty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband   <= 8'd2;
      cfg_q.near_limit <= 8'd5;
      cfg_q.mid_limit  <= 8'd10;
      cfg_q.low_duty   <= 7'd20;
      cfg_q.mid_duty   <= 7'd30;
      cfg_q.max_duty   <= 7'd60;
      cfg_q.ramp_step  <= 6'd10;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEADBAND:   cfg_q.deadband   <= cfg_data_i;
        CFG_NEAR_LIMIT: cfg_q.near_limit <= cfg_data_i;
        CFG_MID_LIMIT:  cfg_q.mid_limit  <= cfg_data_i;
        CFG_LOW_DUTY:   cfg_q.low_duty   <= cfg_data_i[DutyW-1:0];
        CFG_MID_DUTY:   cfg_q.mid_duty   <= cfg_data_i[DutyW-1:0];
        CFG_MAX_DUTY:   cfg_q.max_duty   <= cfg_data_i[DutyW-1:0];
        CFG_RAMP_STEP:  cfg_q.ramp_step  <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  dad_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .measured_i (s_axis_tdata_i[POS_WIDTH-1:0]),
    .target_i   (s_axis_tdata_i[2*POS_WIDTH-1:POS_WIDTH]),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  dad_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  dad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .drive_o     (drive),
    .duty_o      (duty),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutDataW'({duty, drive});

endmodule
`default_nettype wire
